// ===== src/rled_pkg.sv =====
// Shared types, constants and control interface of the run-length encoder.
`timescale 1ns / 1ps

package rled_pkg;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int RUN_LEN_W = 16;
   localparam int DIGIT_W   = 4;

   // Longest run kept before it is closed and a new one of the same byte starts
   localparam logic [RUN_LEN_W-1:0] MAX_RUN = 16'd65535;

   // Decimal digits of the longest count
   localparam int NUM_DIGITS = 5;
   localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT, exact for every 16-bit x
   localparam logic [RUN_LEN_W-1:0] RECIP_TEN   = 16'hCCCD;
   localparam int                   RECIP_SHIFT = 19;

   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_stream;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_item;
      logic              stream_done;
   } rsp_type;

   // Source of an output beat
   typedef enum logic [1:0] {
      SRC_RUN    = 2'd0,
      SRC_DIGIT  = 2'd1,
      SRC_SINGLE = 2'd2
   } src_type;

   typedef struct packed {
      logic    load;
      logic    conv_step;
      logic    push;
      src_type src;
      logic    last;
      logic    done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic dec_has_a;
      logic dec_a_multi;
      logic dec_has_b;
      logic a_multi;
      logic has_b;
      logic eos;
      logic conv_last;
      logic dig_last;
      logic out_free;
   } ctrl_stat_type;

endpackage

// ===== src/rled_ctrl.sv =====
// Sequencing state machine of the run-length encoder.
`timescale 1ns / 1ps

module rled_ctrl
   import rled_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SEND_RUN,
      ST_SEND_DIGIT,
      ST_SEND_SINGLE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Decode commands and next state
   always_comb begin
      cmd       = '0;
      cmd.src   = SRC_RUN;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               if (stat.dec_has_a) begin
                  state_in = stat.dec_a_multi ? ST_CONV : ST_SEND_RUN;
               end else if (stat.dec_has_b) begin
                  state_in = ST_SEND_SINGLE;
               end
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.conv_last) begin
               state_in = ST_SEND_RUN;
            end
         end
         ST_SEND_RUN: begin
            cmd.src  = SRC_RUN;
            cmd.last = !stat.a_multi && !stat.has_b;
            cmd.push = stat.out_free;
            if (stat.out_free) begin
               if (stat.a_multi) begin
                  state_in = ST_SEND_DIGIT;
               end else if (stat.has_b) begin
                  state_in = ST_SEND_SINGLE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SEND_DIGIT: begin
            cmd.src  = SRC_DIGIT;
            cmd.last = stat.dig_last && !stat.has_b;
            cmd.push = stat.out_free;
            if (stat.out_free && stat.dig_last) begin
               state_in = stat.has_b ? ST_SEND_SINGLE : ST_IDLE;
            end
         end
         ST_SEND_SINGLE: begin
            cmd.src  = SRC_SINGLE;
            cmd.last = 1'b1;
            cmd.push = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.done = cmd.last && stat.eos;
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/rled_datapath.sv =====
// Run state, decimal conversion, digit buffer and output register.
`timescale 1ns / 1ps

module rled_datapath
   import rled_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output ctrl_stat_type stat,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   // Open run
   logic [BYTE_W-1:0]    run_byte_ff;
   logic [RUN_LEN_W-1:0] run_length_ff;
   logic                 run_open_ff;

   // Work latched at accept
   logic [BYTE_W-1:0]    a_byte_ff;
   logic [BYTE_W-1:0]    b_byte_ff;
   logic                 a_multi_ff;
   logic                 has_b_ff;
   logic                 eos_ff;

   // Conversion and digit buffer
   logic [RUN_LEN_W-1:0] conv_val_ff;
   logic [DIGIT_W-1:0]   dig_ff [NUM_DIGITS];
   logic [DIG_CNT_W-1:0] nd_ff;
   logic [DIG_IDX_W-1:0] idx_ff;

   // Output register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;

   logic                 same_byte;
   logic                 grow;
   logic                 eos;
   logic [RUN_LEN_W-1:0] run_len_inc;
   logic [RUN_LEN_W-1:0] a_len;
   logic [2*RUN_LEN_W-1:0] prod;
   logic [RUN_LEN_W-1:0] quot;
   logic [RUN_LEN_W-1:0] quot_x10;
   logic [RUN_LEN_W-1:0] rem;
   logic                 out_free;

   // Decode the incoming byte against the open run
   assign eos         = req_data.end_of_stream;
   assign same_byte   = (req_data.in_byte == run_byte_ff);
   assign grow        = run_open_ff && same_byte && (run_length_ff < MAX_RUN);
   assign run_len_inc = run_length_ff + 16'd1;
   assign a_len       = grow ? run_len_inc : run_length_ff;

   // Divide by ten through the reciprocal, one digit a cycle
   assign prod     = {{RUN_LEN_W{1'b0}}, conv_val_ff} * {{RUN_LEN_W{1'b0}}, RECIP_TEN};
   assign quot     = RUN_LEN_W'(prod >> RECIP_SHIFT);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem      = conv_val_ff - quot_x10;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat             = '0;
      stat.dec_has_a   = run_open_ff && (!grow || eos);
      stat.dec_a_multi = (a_len > 16'd1);
      stat.dec_has_b   = eos && !grow;
      stat.a_multi     = a_multi_ff;
      stat.has_b       = has_b_ff;
      stat.eos         = eos_ff;
      stat.conv_last   = (quot == '0);
      stat.dig_last    = (idx_ff == '0);
      stat.out_free    = out_free;
   end

   // Advance the open run on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         run_byte_ff   <= '0;
         run_length_ff <= '0;
         run_open_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (eos) begin
            run_byte_ff   <= '0;
            run_length_ff <= '0;
            run_open_ff   <= 1'b0;
         end else if (grow) begin
            run_length_ff <= run_len_inc;
         end else begin
            run_byte_ff   <= req_data.in_byte;
            run_length_ff <= 16'd1;
            run_open_ff   <= 1'b1;
         end
      end
   end

   // Latch the runs to emit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_byte_ff  <= run_byte_ff;
         b_byte_ff  <= req_data.in_byte;
         a_multi_ff <= stat.dec_a_multi;
         has_b_ff   <= stat.dec_has_b;
         eos_ff     <= eos;
      end
   end

   // Convert the count, least significant digit first
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         conv_val_ff <= a_len;
      end else if (cmd.conv_step) begin
         conv_val_ff   <= quot;
         dig_ff[DIG_IDX_W'(nd_ff)] <= rem[DIGIT_W-1:0];
      end
   end

   // Count digits and walk them back most significant first
   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff  <= '0;
         idx_ff <= '0;
      end else if (cmd.load) begin
         nd_ff <= '0;
      end else if (cmd.conv_step) begin
         nd_ff  <= nd_ff + 1'b1;
         idx_ff <= DIG_IDX_W'(nd_ff);
      end else if (cmd.push && cmd.src == SRC_DIGIT) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   // Select the beat to load
   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.last_of_item = cmd.last;
      rsp_data_in.stream_done  = cmd.done;
      case (cmd.src)
         SRC_RUN:    rsp_data_in.out_byte = a_byte_ff;
         SRC_DIGIT:  rsp_data_in.out_byte = ASCII_ZERO | {4'b0, dig_ff[idx_ff]};
         SRC_SINGLE: rsp_data_in.out_byte = b_byte_ff;
         default:    rsp_data_in.out_byte = b_byte_ff;
      endcase
   end

   // Hold the beat until taken
   always_comb begin
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A beat is loaded only into a free output register
   assert property (@(posedge clock) disable iff (reset) cmd.push |-> out_free)
      else $error("beat pushed over a waiting beat");

   // A pushed beat is offered in the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd.push |=> rsp_valid_ff)
      else $error("pushed beat not offered");

   // A count never has more digits than the buffer holds
   assert property (@(posedge clock) disable iff (reset) nd_ff <= DIG_CNT_W'(NUM_DIGITS))
      else $error("digit buffer overrun");

   // Conversion only runs on a nonzero remainder of the count
   assert property (@(posedge clock) disable iff (reset) cmd.conv_step |-> conv_val_ff != '0)
      else $error("conversion step on zero value");

endmodule

// ===== src/run_length_encoder_decimal.sv =====
// Top level of the run-length encoder with ASCII decimal counts.
//
// Input channel req_*: one uncompressed byte per beat, with end_of_stream on
// the final byte of a stream. Output channel rsp_*: one encoded byte per
// beat; last_of_item marks the final beat caused by an input beat and
// stream_done the final beat of a stream.
// A byte that extends the open run gives no beat; the next byte can follow
// at once. A byte that closes a run of one goes to the run-send state: its
// beat is loaded into the output register once that is free and is offered
// from there, when the next byte can be taken. Closing a longer run first
// converts the count, one digit per cycle (a shared divide-by-ten unit), then
// sends one beat per cycle for the byte and each digit while the receiver
// takes them, plus one beat for a final run of one: at most 7 beats.
// Output beats sit in one output register; a stalled receiver holds the
// sequencer, and the input is taken again once the final beat is loaded.
// Reset clears the open run and the output register; the next byte starts
// a new stream.
`timescale 1ns / 1ps

module run_length_encoder_decimal
   import rled_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   rled_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rled_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
